// File: hw/rtl/mpeg2_hfe_pkg.sv
// ----------------------------------------------------------------------------
// mpeg2_hfe_pkg
// Shared types and codes for the MPEG-2 start-code header field extractor.
// ----------------------------------------------------------------------------
package mpeg2_hfe_pkg;

    // Start-code values
    localparam logic [7:0] CODE_SEQ = 8'hB3;
    localparam logic [7:0] CODE_GOP = 8'hB8;

    // Register reset values
    localparam logic [7:0] STREAM_ID_RESET = 8'hE0;
    localparam logic [2:0] ENABLE_RESET    = 3'b111;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_STREAM_ID = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE    = 2'd1;

    // Enable bits
    localparam int unsigned EN_SEQ = 0;
    localparam int unsigned EN_GOP = 1;
    localparam int unsigned EN_PES = 2;

    // Capture kinds
    localparam logic [1:0] CAP_IDLE = 2'd0;
    localparam logic [1:0] CAP_SEQ  = 2'd1;
    localparam logic [1:0] CAP_GOP  = 2'd2;
    localparam logic [1:0] CAP_PES  = 2'd3;

    // Reported header kinds
    localparam logic [1:0] HDR_SEQ = 2'd0;
    localparam logic [1:0] HDR_GOP = 2'd1;
    localparam logic [1:0] HDR_PTS = 2'd2;

    // Byte positions within a capture (count after the byte is taken)
    localparam logic [3:0] SEQ_GOP_LAST  = 4'd4;
    localparam logic [3:0] PES_FLAGS_POS = 4'd4;
    localparam logic [3:0] PES_PTS_FIRST = 4'd6;
    localparam logic [3:0] PES_LAST      = 4'd10;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  header_kind;
        logic [11:0] width;
        logic [11:0] height;
        logic [3:0]  aspect_code;
        logic [3:0]  rate_code;
        logic        drop_frame;
        logic [4:0]  tc_hours;
        logic [5:0]  tc_minutes;
        logic [5:0]  tc_seconds;
        logic [5:0]  tc_frames;
        logic [1:0]  gop_flags;
        logic [32:0] pts;
    } t_out_item;

endpackage

// File: hw/rtl/mpeg2_header_field_extractor_core.sv
// ----------------------------------------------------------------------------
// mpeg2_header_field_extractor_core
// Scans an MPEG-2 byte stream for start codes and reports sequence header,
// GOP header and PES PTS fields.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+------------------------
//  in       | in        | i_in_valid / o_in_stall    | i_in_data  (t_in_item)
//  out      | out       | o_out_valid / i_out_stall  | o_out_data (t_out_item)
//  cfg      | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
//  One byte per clock while the input is not stalled; a result is registered into
//  the output register, or into the skid entry while the output register is held.
//  A one-entry skid register behind the output register keeps input flowing
//  while a result waits; input stalls only while the skid entry is occupied.
//  Reset is synchronous: detector to all ones, capture idle, registers to
//  stream id E0 and all headers enabled.
//
module mpeg2_header_field_extractor_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    input  mpeg2_hfe_pkg::t_in_item               i_in_data,
    output logic                                  o_in_stall,
    output logic                                  o_out_valid,
    output mpeg2_hfe_pkg::t_out_item              o_out_data,
    input  logic                                  i_out_stall,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [mpeg2_hfe_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [7:0]                            i_cfg_data
);

    logic [7:0]  r_stream_id;
    logic [2:0]  r_enable;

    logic [23:0] r_recent, n_recent;
    logic [1:0]  r_kind, n_kind;
    logic [3:0]  r_count, n_count;
    logic [39:0] r_bits, n_bits;
    logic        r_flagged, n_flagged;

    logic                     r_out_valid;
    mpeg2_hfe_pkg::t_out_item r_out;
    logic                     r_skid_valid;
    mpeg2_hfe_pkg::t_out_item r_skid;

    logic                     in_accept;
    logic                     out_take;
    logic                     res_valid;
    mpeg2_hfe_pkg::t_out_item res;

    // effective state after an optional restart
    logic [23:0] e_recent;
    logic [1:0]  e_kind;
    logic [3:0]  e_count;
    logic [39:0] e_bits;
    logic        e_flagged;
    logic        is_code;
    logic [7:0]  b;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_skid_valid;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_take    = r_out_valid && !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        b         = i_in_data.data_byte;
        e_recent  = i_in_data.restart ? 24'hFFFFFF : r_recent;
        e_kind    = i_in_data.restart ? mpeg2_hfe_pkg::CAP_IDLE : r_kind;
        e_count   = i_in_data.restart ? 4'd0 : r_count;
        e_bits    = i_in_data.restart ? 40'd0 : r_bits;
        e_flagged = i_in_data.restart ? 1'b0 : r_flagged;

        is_code   = (e_recent == 24'h000001);
        n_recent  = {e_recent[15:0], b};
        n_kind    = e_kind;
        n_count   = e_count;
        n_bits    = e_bits;
        n_flagged = e_flagged;
        res_valid = 1'b0;
        res       = '0;

        if (is_code) begin
            // start code wins over any running capture
            n_count   = 4'd0;
            n_bits    = 40'd0;
            n_flagged = 1'b0;
            if (b == mpeg2_hfe_pkg::CODE_SEQ && r_enable[mpeg2_hfe_pkg::EN_SEQ]) begin
                n_kind = mpeg2_hfe_pkg::CAP_SEQ;
            end else if (b == mpeg2_hfe_pkg::CODE_GOP && r_enable[mpeg2_hfe_pkg::EN_GOP]) begin
                n_kind = mpeg2_hfe_pkg::CAP_GOP;
            end else if (b == r_stream_id && r_enable[mpeg2_hfe_pkg::EN_PES]) begin
                n_kind = mpeg2_hfe_pkg::CAP_PES;
            end else begin
                n_kind = mpeg2_hfe_pkg::CAP_IDLE;
            end
        end else begin
            n_count = e_count + 4'd1;
            case (e_kind)
                mpeg2_hfe_pkg::CAP_SEQ, mpeg2_hfe_pkg::CAP_GOP: begin
                    n_bits = {e_bits[31:0], b};
                    if (n_count == mpeg2_hfe_pkg::SEQ_GOP_LAST) begin
                        res_valid = 1'b1;
                        if (e_kind == mpeg2_hfe_pkg::CAP_SEQ) begin
                            res.header_kind = mpeg2_hfe_pkg::HDR_SEQ;
                            res.width       = n_bits[31:20];
                            res.height      = n_bits[19:8];
                            res.aspect_code = n_bits[7:4];
                            res.rate_code   = n_bits[3:0];
                        end else begin
                            res.header_kind = mpeg2_hfe_pkg::HDR_GOP;
                            res.drop_frame  = n_bits[31];
                            res.tc_hours    = n_bits[30:26];
                            res.tc_minutes  = n_bits[25:20];
                            // bit 19 is a marker
                            res.tc_seconds  = n_bits[18:13];
                            res.tc_frames   = n_bits[12:7];
                            res.gop_flags   = n_bits[6:5];
                        end
                        n_kind    = mpeg2_hfe_pkg::CAP_IDLE;
                        n_count   = 4'd0;
                        n_bits    = 40'd0;
                        n_flagged = 1'b0;
                    end
                end
                mpeg2_hfe_pkg::CAP_PES: begin
                    if (n_count == mpeg2_hfe_pkg::PES_FLAGS_POS) begin
                        n_flagged = b[7];
                    end
                    if (n_count >= mpeg2_hfe_pkg::PES_PTS_FIRST) begin
                        n_bits = {e_bits[31:0], b};
                    end
                    if (n_count == mpeg2_hfe_pkg::PES_LAST) begin
                        res_valid       = e_flagged;
                        res.header_kind = mpeg2_hfe_pkg::HDR_PTS;
                        res.pts         = {n_bits[35:33], n_bits[31:17], n_bits[15:1]};
                        n_kind    = mpeg2_hfe_pkg::CAP_IDLE;
                        n_count   = 4'd0;
                        n_bits    = 40'd0;
                        n_flagged = 1'b0;
                    end
                end
                default: begin
                    // idle: nothing counted
                    n_count = e_count;
                end
            endcase
        end
    end

    // configuration and scanner state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stream_id <= mpeg2_hfe_pkg::STREAM_ID_RESET;
            r_enable    <= mpeg2_hfe_pkg::ENABLE_RESET;
            r_recent    <= 24'hFFFFFF;
            r_kind      <= mpeg2_hfe_pkg::CAP_IDLE;
            r_count     <= 4'd0;
            r_bits      <= 40'd0;
            r_flagged   <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == mpeg2_hfe_pkg::CFG_STREAM_ID) begin
                    r_stream_id <= i_cfg_data;
                end else if (i_cfg_index == mpeg2_hfe_pkg::CFG_ENABLE) begin
                    r_enable <= i_cfg_data[2:0];
                end
            end
            if (in_accept) begin
                r_recent  <= n_recent;
                r_kind    <= n_kind;
                r_count   <= n_count;
                r_bits    <= n_bits;
                r_flagged <= n_flagged;
            end
        end
    end

    // output register and skid entry: valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (in_accept && res_valid) begin
            if (r_out_valid && !out_take) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register and skid entry: payload
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out <= r_skid;
            end
        end else if (in_accept && res_valid) begin
            if (r_out_valid && !out_take) begin
                r_skid <= res;
            end else begin
                r_out <= res;
            end
        end
    end

endmodule
